>>> hdl/bpa_pkg.sv
// Shared constants, types and a helper function for the buddy page allocator.
// Depends on nothing; the node unit and the top of the allocator import this package.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   // Pool size and the tree that follows from it (heap numbering, root at node 1)
   localparam int POOL_PAGES  = 1024;
   localparam int TREE_PAGES  = 1 << $clog2(POOL_PAGES);
   localparam int TREE_LEVELS = $clog2(TREE_PAGES);
   localparam int NODE_AW     = TREE_LEVELS + 1;
   localparam int RAM_DEPTH   = 1 << NODE_AW;
   localparam int SIZE_W      = TREE_LEVELS + 1;

   // Field widths of the request and response
   localparam int COUNT_W = 11;
   localparam int FRAME_W = 10;
   localparam int WANT_W  = COUNT_W + 1;
   localparam int CMP_W   = (WANT_W > SIZE_W) ? WANT_W : SIZE_W;
   localparam int SUM_W   = SIZE_W + 1;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);
   localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(2 * TREE_PAGES - 1);

   typedef struct packed {
      logic [SIZE_W-1:0] cur;
      logic [SIZE_W-1:0] sib;
      logic [WANT_W-1:0] want;
      logic [SIZE_W-1:0] psize;
   } unit_in_type;

   typedef struct packed {
      logic              fit;
      logic [SIZE_W-1:0] merged;
   } unit_out_type;

   // Round a page count up to a power of two, zero counting as one.
   // The bit smear covers up to sixteen bits, enough for the count field.
   function automatic logic [WANT_W-1:0] round_up_pow2(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] v;
      v = count - COUNT_W'(1);
      v = v | (v >> 1);
      v = v | (v >> 2);
      v = v | (v >> 4);
      v = v | (v >> 8);
      if (count == '0) begin
         return WANT_W'(1);
      end
      return {1'b0, v} + WANT_W'(1);
   endfunction

endpackage

`default_nettype wire

>>> hdl/bpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the free-size tree of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/bpa_node_unit.sv
// Shared node arithmetic: the fit compare for the descent and the
// buddy merge (sum against parent size, else maximum) for the climb.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_node_unit
   import bpa_pkg::*;
(
   input  wire unit_in_type  unit_in,
   output unit_out_type      unit_out
);

   logic [SUM_W-1:0]  pair_sum;
   logic [SIZE_W-1:0] larger;

   assign pair_sum = SUM_W'(unit_in.cur) + SUM_W'(unit_in.sib);
   assign larger   = (unit_in.cur > unit_in.sib) ? unit_in.cur : unit_in.sib;

   // Two wholly free buddies merge back into one block of the parent's size.
   assign unit_out.merged = (pair_sum == SUM_W'(unit_in.psize)) ? unit_in.psize : larger;
   assign unit_out.fit    = CMP_W'(unit_in.cur) >= CMP_W'(unit_in.want);

endmodule

`default_nettype wire

>>> hdl/buddy_page_allocator.sv
// Buddy page allocator: an allocate that fails or takes the whole pool answers straight
// after the root check, otherwise it descends to a block L levels below the root and climbs
// back to it; a free climbs from its leaf to the used block and merges on the way up.
// One tree node is read per cycle through the single read port of the tree RAM, and a
// response still waiting for its transfer holds the block in its last step.
// After reset a clearing pass writes every node's full size, taking no request.
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator
   import bpa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // operation[0], page_count[11:1], frame_number[21:12]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata   // granted_frame[9:0], ok[10]
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_ROOT  = 7'b0000100,
      ST_DOWN  = 7'b0001000,
      ST_CLIMB = 7'b0010000,
      ST_UP    = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [NODE_AW-1:0]     node_ff, node_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [WANT_W-1:0]      want_ff, want_in;
   logic [SIZE_W-1:0]      val_ff, val_in;
   logic [TREE_LEVELS-1:0] base_ff, base_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_ok_ff, rsp_ok_in;

   logic                   req_op;
   logic [COUNT_W-1:0]     req_count;
   logic [FRAME_W-1:0]     req_frame;
   logic                   req_xfer;
   logic [NODE_AW-1:0]     req_leaf;
   logic                   req_out_of_pool;

   logic                   wr_en;
   logic [NODE_AW-1:0]     wr_addr;
   logic [SIZE_W-1:0]      wr_data;
   logic [NODE_AW-1:0]     rd_addr;
   logic [SIZE_W-1:0]      rd_data;

   logic [NODE_AW-1:0]     left_child;
   logic [NODE_AW-1:0]     parent;
   logic [NODE_AW-1:0]     next_node;
   logic [SIZE_W-1:0]      half_size;
   logic [SIZE_W-1:0]      double_size;

   unit_in_type            unit_in;
   unit_out_type           unit_out;

   assign req_op    = req_tdata[0];
   assign req_count = req_tdata[COUNT_W:1];
   assign req_frame = req_tdata[COUNT_W+FRAME_W:COUNT_W+1];
   assign req_xfer  = req_tvalid && req_tready;
   assign req_leaf  = NODE_AW'(req_frame) + NODE_AW'(TREE_PAGES);
   assign req_out_of_pool = NODE_AW'(req_frame) >= NODE_AW'(TREE_PAGES);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - FRAME_W - 1)'(0), rsp_ok_ff, rsp_frame_ff};

   assign left_child  = {node_ff[NODE_AW-2:0], 1'b0};
   assign parent      = {1'b0, node_ff[NODE_AW-1:1]};
   assign half_size   = {1'b0, size_ff[SIZE_W-1:1]};
   assign double_size = {size_ff[SIZE_W-2:0], 1'b0};
   assign next_node   = unit_out.fit ? left_child : (left_child | NODE_AW'(1));

   // During the climb the unit merges the carried value with its buddy just read;
   // otherwise it compares the node just read against the wanted size.
   assign unit_in.cur   = (state_ff == ST_UP) ? val_ff : rd_data;
   assign unit_in.sib   = rd_data;
   assign unit_in.want  = want_ff;
   assign unit_in.psize = double_size;

   bpa_node_unit u_node_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   bpa_ram #(
      .DATA_W (SIZE_W),
      .DEPTH  (RAM_DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      want_in      = want_ff;
      val_in       = val_ff;
      base_in      = base_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_frame_in = rsp_frame_ff;
      rsp_ok_in    = rsp_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = size_ff;
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + NODE_AW'(1);
               // The size halves when the next node opens a new level.
               if (((node_ff + NODE_AW'(1)) & node_ff) == '0) begin
                  size_in = half_size;
               end
            end
         end

         ST_IDLE: begin
            rd_addr = (req_op == OP_FREE) ? req_leaf : ROOT_NODE;
            if (req_xfer) begin
               want_in = round_up_pow2(req_count);
               base_in = '0;
               ok_in   = 1'b1;
               if (req_op == OP_ALLOC) begin
                  node_in  = ROOT_NODE;
                  size_in  = SIZE_W'(TREE_PAGES);
                  state_in = ST_ROOT;
               end else if (req_out_of_pool) begin
                  state_in = ST_DONE;
               end else begin
                  node_in  = req_leaf;
                  size_in  = SIZE_W'(1);
                  state_in = ST_CLIMB;
               end
            end
         end

         ST_ROOT: begin
            if ((want_ff > WANT_W'(TREE_PAGES)) || !unit_out.fit) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else if (WANT_W'(size_ff) == want_ff) begin
               wr_en    = 1'b1;
               wr_addr  = ROOT_NODE;
               wr_data  = '0;
               state_in = ST_DONE;
            end else begin
               rd_addr  = left_child;
               state_in = ST_DOWN;
            end
         end

         ST_DOWN: begin
            // The left child of the current node has just been read.
            node_in = next_node;
            size_in = half_size;
            if (!unit_out.fit) begin
               base_in = base_ff + TREE_LEVELS'(half_size);
            end
            if (WANT_W'(half_size) == want_ff) begin
               wr_en    = 1'b1;
               wr_addr  = next_node;
               wr_data  = '0;
               val_in   = '0;
               rd_addr  = next_node ^ NODE_AW'(1);
               state_in = ST_UP;
            end else begin
               rd_addr = {next_node[NODE_AW-2:0], 1'b0};
            end
         end

         ST_CLIMB: begin
            if (rd_data == '0) begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_data = size_ff;
               val_in  = size_ff;
               if (node_ff == ROOT_NODE) begin
                  state_in = ST_DONE;
               end else begin
                  rd_addr  = node_ff ^ NODE_AW'(1);
                  state_in = ST_UP;
               end
            end else if (node_ff == ROOT_NODE) begin
               state_in = ST_DONE;
            end else begin
               node_in = parent;
               size_in = double_size;
               rd_addr = parent;
            end
         end

         ST_UP: begin
            // The buddy of the current node has just been read; refresh the parent
            // and fetch the parent's buddy in the same cycle.
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = unit_out.merged;
            node_in = parent;
            size_in = double_size;
            val_in  = unit_out.merged;
            if (parent == ROOT_NODE) begin
               state_in = ST_DONE;
            end else begin
               rd_addr = parent ^ NODE_AW'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = ok_ff ? FRAME_W'(base_ff) : '0;
               rsp_ok_in    = ok_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= ROOT_NODE;
         size_ff      <= SIZE_W'(TREE_PAGES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      val_ff       <= val_in;
      base_ff      <= base_in;
      ok_ff        <= ok_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   // A node is never read in the cycle that it is written.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != rd_addr))
      else $error("tree read and write collide on one node");

   // A request is not taken while another one is still being worked on.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while another is in progress");

   // A failed allocate never reports a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_frame_ff == '0))
      else $error("failed allocate carries a frame");

   // The descent stops before the node size falls to the wanted size.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN) |-> (WANT_W'(size_ff) > want_ff))
      else $error("descent went below the wanted block size");

endmodule

`default_nettype wire

>>> dv/bpa_checker.sv
// Checker for the buddy page allocator: watches the request and response streams,
// keeps its own longest-free tree and compares each response with the predicted grant.
// Depends on bpa_pkg for widths, pool size and operation codes.
`timescale 1ns / 1ps

module bpa_checker
   import bpa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // operation[0], page_count[11:1], frame_number[21:12]
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,  // granted_frame[9:0], ok[10]
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               ok;
   } grant_type;

   // Heap numbering: node 1 is the root, children of n are 2n and 2n+1,
   // and the leaves TREE_PAGES .. 2*TREE_PAGES-1 stand for frames 0 upwards.
   logic [SIZE_W-1:0] page_tree [1:2*TREE_PAGES-1];
   grant_type         grants_due[$];
   int                mismatch_total = 0;

   task automatic report_mismatch(input string msg);
      $display("bpa_checker: mismatch at %0t: %s", $realtime, msg);
      mismatch_total++;
   endtask

   function automatic logic [SIZE_W-1:0] wider(input logic [SIZE_W-1:0] a,
                                               input logic [SIZE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   task automatic init_tree();
      int first;
      int span;
      span = TREE_PAGES;
      for (first = 1; first < 2 * TREE_PAGES; first = first * 2) begin
         for (int n = first; n < 2 * first; n++) begin
            page_tree[n] = SIZE_W'(span);
         end
         span = span / 2;
      end
   endtask

   task automatic predict_alloc(input logic [COUNT_W-1:0] count, output grant_type g);
      logic [WANT_W-1:0] want;
      logic [WANT_W-1:0] span;
      int                node;
      want = WANT_W'(1);
      while (want < {1'b0, count}) begin
         want = want << 1;
      end
      g.frame = '0;
      g.ok    = 1'b0;
      if (want > WANT_W'(TREE_PAGES) || WANT_W'(page_tree[1]) < want) begin
         return;
      end
      node = 1;
      span = WANT_W'(TREE_PAGES);
      while (span != want) begin
         if (WANT_W'(page_tree[2 * node]) >= want) begin
            node = 2 * node;
         end else begin
            node = 2 * node + 1;
         end
         span = span >> 1;
      end
      page_tree[node] = '0;
      g.frame = FRAME_W'(node * int'(span) - TREE_PAGES);
      g.ok    = 1'b1;
      while (node != 1) begin
         node = node / 2;
         page_tree[node] = wider(page_tree[2 * node], page_tree[2 * node + 1]);
      end
   endtask

   task automatic free_block(input logic [FRAME_W-1:0] frame);
      int              node;
      logic [SIZE_W:0] span;
      logic [SIZE_W:0] pair;
      if (int'(frame) >= TREE_PAGES) begin
         return;
      end
      node = int'(frame) + TREE_PAGES;
      span = 1;
      // Climb to the used node that covers this frame, if there is one.
      while (page_tree[node] != '0) begin
         if (node == 1) begin
            return;
         end
         node = node / 2;
         span = span << 1;
      end
      page_tree[node] = SIZE_W'(span);
      while (node != 1) begin
         node = node / 2;
         span = span << 1;
         pair = {1'b0, page_tree[2 * node]} + {1'b0, page_tree[2 * node + 1]};
         if (pair == span) begin
            page_tree[node] = SIZE_W'(span);
         end else begin
            page_tree[node] = wider(page_tree[2 * node], page_tree[2 * node + 1]);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      grant_type seen;
      grant_type due;
      grant_type fresh;
      if (reset) begin
         init_tree();
         grants_due.delete();
      end else begin
         // The response side goes first: a response can never belong to a
         // request accepted on the same edge.
         if (rsp_tvalid && rsp_tready) begin
            seen.frame = rsp_tdata[FRAME_W-1:0];
            seen.ok    = rsp_tdata[FRAME_W];
            if (grants_due.size() == 0) begin
               report_mismatch($sformatf("response with nothing due: frame %0d ok %0b",
                                         seen.frame, seen.ok));
            end else begin
               due = grants_due.pop_front();
               if (seen.frame != due.frame) begin
                  report_mismatch($sformatf("granted_frame %0d, predicted %0d",
                                            seen.frame, due.frame));
               end
               if (seen.ok != due.ok) begin
                  report_mismatch($sformatf("ok %0b, predicted %0b", seen.ok, due.ok));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata[0] == OP_ALLOC) begin
               predict_alloc(req_tdata[COUNT_W:1], fresh);
            end else begin
               free_block(req_tdata[COUNT_W+FRAME_W:COUNT_W+1]);
               fresh.frame = '0;
               fresh.ok    = 1'b1;
            end
            grants_due.push_back(fresh);
         end
      end
      fail_count <= mismatch_total;
      pending    <= grants_due.size();
   end

endmodule

>>> dv/tb_top.sv
// Top of the buddy page allocator testbench: clock, reset, request and response drivers.
// Depends on bpa_pkg, buddy_page_allocator and bpa_checker, which does all the checking.
`timescale 1ns / 1ps

module tb_top
   import bpa_pkg::*;
();

   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic               op;
      logic [COUNT_W-1:0] count;
   } sent_type;

   typedef struct {
      logic [FRAME_W-1:0] frame;
      int                 span;
   } live_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;

   sent_type sent_q[$];
   live_type live_q[$];
   int       hold_asked = 0;
   bit       steady     = 1'b0;

   buddy_page_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bpa_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Receiver: random back-pressure (none while steady), with a long hold-off whenever one is asked for.
   initial begin : rsp_side
      int hold_served;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   // Keep the blocks that have been granted, so that most frees are well formed.
   always @(posedge clock) begin : track_grants
      sent_type sent;
      int       span;
      if (!reset && rsp_tvalid && rsp_tready && sent_q.size() != 0) begin
         sent = sent_q.pop_front();
         if (sent.op == OP_ALLOC && rsp_tdata[FRAME_W]) begin
            span = 1;
            while (span < int'(sent.count)) begin
               span = span * 2;
            end
            live_q.push_back('{rsp_tdata[FRAME_W-1:0], span});
         end
      end
   end

   task automatic send_req(input logic op, input logic [COUNT_W-1:0] count,
                           input logic [FRAME_W-1:0] frame);
      req_tdata  <= REQ_W'({frame, count, op});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_q.push_back('{op, count});
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int                 pick;
      int                 w;
      int                 k;
      int                 c;
      live_type           blk;
      logic [FRAME_W-1:0] f;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // Noise: a free of any frame, used or not.
            send_req(OP_FREE, COUNT_W'($urandom), FRAME_W'($urandom));
         end else if (live_q.size() != 0 && pick < (live_q.size() > 24 ? 55 : 35)) begin
            k   = $urandom_range(0, live_q.size() - 1);
            blk = live_q[k];
            live_q.delete(k);
            f = blk.frame;
            if ($urandom_range(0, 3) == 0) begin
               f = f + FRAME_W'($urandom_range(0, blk.span - 1));
            end
            send_req(OP_FREE, COUNT_W'($urandom), f);
         end else begin
            w = $urandom_range(0, 99);
            if (w < 50) begin
               c = $urandom_range(0, 4);
            end else if (w < 80) begin
               c = $urandom_range(5, 64);
            end else if (w < 95) begin
               c = $urandom_range(65, 512);
            end else if (w < 99) begin
               c = $urandom_range(513, 1024);
            end else begin
               c = $urandom_range(1025, 2047);
            end
            send_req(OP_ALLOC, COUNT_W'(c), FRAME_W'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero count, oversize requests, frees that miss,
      // frees from inside a block, the whole pool and a buddy merge.
      send_req(OP_ALLOC, 11'd0, 10'd0);
      send_req(OP_ALLOC, 11'd1, 10'd1023);
      send_req(OP_ALLOC, 11'd2, 10'd0);
      send_req(OP_ALLOC, 11'd1025, 10'd0);
      send_req(OP_ALLOC, 11'd2047, 10'd0);
      send_req(OP_ALLOC, 11'd1024, 10'd0);
      send_req(OP_FREE, 11'd0, 10'd1);
      send_req(OP_FREE, 11'd0, 10'd1);
      send_req(OP_FREE, 11'd2047, 10'd3);
      send_req(OP_FREE, 11'd0, 10'd0);
      send_req(OP_ALLOC, 11'd1024, 10'd0);
      send_req(OP_ALLOC, 11'd1, 10'd0);
      send_req(OP_FREE, 11'd0, 10'd1023);
      send_req(OP_ALLOC, 11'd512, 10'd0);
      send_req(OP_ALLOC, 11'd512, 10'd0);
      send_req(OP_FREE, 11'd0, 10'd512);
      send_req(OP_FREE, 11'd0, 10'd0);
      send_req(OP_ALLOC, 11'd3, 10'd0);
      send_req(OP_FREE, 11'd0, 10'd1023);
      send_req(OP_FREE, 11'd1365, 10'd682);
      send_req(OP_FREE, 11'd682, 10'd341);
      send_req(OP_FREE, 11'd0, 10'd2);
      send_req(OP_ALLOC, 11'd1023, 10'd0);
      send_req(OP_FREE, 11'd0, 10'd0);
      wait_drained();
      live_q.delete();

      random_phase(400);
      // Long receiver hold-off while requests keep coming, then a full drain.
      hold_asked++;
      random_phase(40);
      wait_drained();
      steady = 1'b1;
      random_phase(300);
      steady = 1'b0;
      hold_asked++;
      random_phase(460);

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
